>>> sv/evb_pkg.sv
// ----------------------------------------------------------------------------
// evb_pkg
// Types and constants shared by the variogram binner: request and result
// layouts, the token that walks the cell chain, command, method and status
// codes, and the controller states.
// ----------------------------------------------------------------------------
package evb_pkg;

	localparam int BINS       = 32;
	localparam int AXES       = 3;
	localparam int VALUE_BITS = 12;

	localparam int COORD_W = 16;
	localparam int BIN_W   = 5;
	localparam int IDX_W   = 6;
	localparam int EDGE_W  = 36;
	localparam int SUM_W   = 48;
	localparam int SQ_W    = 64;
	localparam int CNT_W   = 24;
	localparam int HT_W    = 40;
	localparam int TERM_W  = 25;
	localparam int TSQ_W   = 48;
	localparam int OUT_W   = 48;
	localparam int WIDE_W  = 128;
	localparam int OP_W    = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [1:0] CMD_ACC   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] MTH_VARIO = 2'd0;
	localparam logic [1:0] MTH_COV   = 2'd1;
	localparam logic [1:0] MTH_MADO  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_ORDER = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_METHOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BINS   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_PASS, S_LOAD, S_MUL, S_DLOAD, S_DIV, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]                    command;
		logic signed [COORD_W-1:0]     head_x;
		logic signed [COORD_W-1:0]     head_y;
		logic signed [COORD_W-1:0]     head_z;
		logic signed [COORD_W-1:0]     tail_x;
		logic signed [COORD_W-1:0]     tail_y;
		logic signed [COORD_W-1:0]     tail_z;
		logic signed [VALUE_BITS-1:0]  head_value;
		logic signed [VALUE_BITS-1:0]  tail_value;
		logic [IDX_W-1:0]              bin_index;
		logic signed [EDGE_W-1:0]      edge_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [BIN_W-1:0]         bin_hit;
		logic [CNT_W-1:0]         pair_count;
		logic signed [OUT_W-1:0]  mean_value;
		logic signed [OUT_W-1:0]  spread_value;
		logic                     spread_valid;
	} res_t;

	typedef struct packed {
		logic                          valid;
		logic                          apply;
		logic [1:0]                    cmd;
		logic [1:0]                    method;
		logic [IDX_W-1:0]              nb;
		logic [IDX_W-1:0]              idx;
		logic signed [EDGE_W-1:0]      sq_dist;
		logic signed [TERM_W-1:0]      term;
		logic [TSQ_W-1:0]              term_sq;
		logic signed [VALUE_BITS-1:0]  hv;
		logic signed [VALUE_BITS-1:0]  tv;
		logic signed [EDGE_W-1:0]      edge_val;
		logic signed [EDGE_W-1:0]      prev_edge;
		logic                          bad;
		logic                          found;
		logic [BIN_W-1:0]              bin;
		logic [CNT_W-1:0]              n;
		logic signed [SUM_W-1:0]       s;
		logic [SQ_W-1:0]               q;
		logic signed [HT_W-1:0]        hs;
		logic signed [HT_W-1:0]        ts;
	} tok_t;

endpackage

>>> sv/evb_cell.sv
// ----------------------------------------------------------------------------
// evb_cell
// One link of the bin chain: holds edge slot IDX and, below the last slot,
// the accumulators of bin IDX. Checks, loads or updates the passing token and
// hands it to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module evb_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  evb_pkg::tok_t tok_i,
	output evb_pkg::tok_t tok_o
);
	import evb_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [BIN_W-1:0] MY_BIN = BIN_W'(IDX);
	localparam logic [BIN_W-1:0] LO_BIN = BIN_W'(IDX - 1);
	localparam bit HAS_BIN = (IDX < BINS);

	logic signed [EDGE_W-1:0] edge_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]          sq_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [HT_W-1:0]   hs_q;
	logic signed [HT_W-1:0]   ts_q;
	tok_t                     tok_d;
	tok_t                     tok_q;

	always_ff @(posedge clk) begin
		if (tok_i.valid && tok_i.cmd == CMD_WRITE && tok_i.idx == MY_IDX) begin
			edge_q <= tok_i.edge_val;
		end
	end

	generate
		if (HAS_BIN) begin : g_bin
			logic                     hit;
			logic signed [SUM_W:0]    sum_w;
			logic signed [SUM_W-1:0]  sum_n;
			logic [SQ_W:0]            sq_w;
			logic [SQ_W-1:0]          sq_n;
			logic signed [HT_W:0]     hs_w;
			logic signed [HT_W:0]     ts_w;
			logic signed [HT_W-1:0]   hs_n;
			logic signed [HT_W-1:0]   ts_n;

			assign hit = tok_i.valid && tok_i.cmd == CMD_ACC && tok_i.apply
				&& tok_i.bin == MY_BIN && cnt_q != '1;

			always_comb begin
				sum_w = (SUM_W+1)'(sum_q) + (SUM_W+1)'(tok_i.term);
				if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
					sum_n = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
						: {1'b0, {(SUM_W-1){1'b1}}};
				end else begin
					sum_n = sum_w[SUM_W-1:0];
				end
				sq_w = {1'b0, sq_q} + (SQ_W+1)'(tok_i.term_sq);
				sq_n = sq_w[SQ_W-1] ? {1'b0, {(SQ_W-1){1'b1}}} : sq_w[SQ_W-1:0];
				hs_w = (HT_W+1)'(hs_q) + (HT_W+1)'(tok_i.hv);
				ts_w = (HT_W+1)'(ts_q) + (HT_W+1)'(tok_i.tv);
				if (hs_w[HT_W] != hs_w[HT_W-1]) begin
					hs_n = hs_w[HT_W] ? {1'b1, {(HT_W-1){1'b0}}} : {1'b0, {(HT_W-1){1'b1}}};
				end else begin
					hs_n = hs_w[HT_W-1:0];
				end
				if (ts_w[HT_W] != ts_w[HT_W-1]) begin
					ts_n = ts_w[HT_W] ? {1'b1, {(HT_W-1){1'b0}}} : {1'b0, {(HT_W-1){1'b1}}};
				end else begin
					ts_n = ts_w[HT_W-1:0];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sum_q <= '0;
					sq_q  <= '0;
					cnt_q <= '0;
					hs_q  <= '0;
					ts_q  <= '0;
				end else if (tok_i.valid && tok_i.cmd == CMD_CLEAR) begin
					sum_q <= '0;
					sq_q  <= '0;
					cnt_q <= '0;
					hs_q  <= '0;
					ts_q  <= '0;
				end else if (hit) begin
					sum_q <= sum_n;
					sq_q  <= sq_n;
					cnt_q <= cnt_q + 1'b1;
					if (tok_i.method == MTH_COV) begin
						hs_q <= hs_n;
						ts_q <= ts_n;
					end
				end
			end
		end else begin : g_edge_only
			assign sum_q = '0;
			assign sq_q  = '0;
			assign cnt_q = '0;
			assign hs_q  = '0;
			assign ts_q  = '0;
		end
	endgenerate

	always_comb begin
		tok_d = tok_i;
		tok_d.prev_edge = edge_q;
		if (tok_i.valid && tok_i.cmd == CMD_ACC && !tok_i.apply && IDX >= 1
				&& MY_IDX <= tok_i.nb) begin
			if (tok_i.prev_edge >= edge_q) begin
				tok_d.bad = 1'b1;
			end
			if (tok_i.sq_dist > tok_i.prev_edge && tok_i.sq_dist <= edge_q) begin
				tok_d.found = 1'b1;
				tok_d.bin   = LO_BIN;
			end
		end
		if (HAS_BIN && tok_i.valid && tok_i.cmd == CMD_READ && tok_i.idx == MY_IDX) begin
			tok_d.n  = cnt_q;
			tok_d.s  = sum_q;
			tok_d.q  = sq_q;
			tok_d.hs = hs_q;
			tok_d.ts = ts_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> sv/evb_mul.sv
// ----------------------------------------------------------------------------
// evb_mul
// Shift-and-add multiplier, 64 by 64 bits unsigned, one multiplier bit per
// cycle. Done pulses for one cycle when the product is ready.
// ----------------------------------------------------------------------------
module evb_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [evb_pkg::OP_W-1:0]    a,
	input  logic [evb_pkg::OP_W-1:0]    b,
	output logic                        done,
	output logic [evb_pkg::WIDE_W-1:0]  prod
);
	import evb_pkg::*;

	localparam int CNT_BITS = $clog2(OP_W);

	logic [WIDE_W-1:0]   acc_q;
	logic [WIDE_W-1:0]   mcand_q;
	logic [OP_W-1:0]     mplier_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                run_q;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= WIDE_W'(a);
			mplier_q <= b;
		end else if (run_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> sv/evb_div.sv
// ----------------------------------------------------------------------------
// evb_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit per
// cycle. Done pulses for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module evb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [evb_pkg::WIDE_W-1:0]  num,
	input  logic [evb_pkg::OP_W-1:0]    den,
	output logic                        done,
	output logic [evb_pkg::WIDE_W-1:0]  quo,
	output logic [evb_pkg::OP_W-1:0]    rem
);
	import evb_pkg::*;

	localparam int CNT_BITS = $clog2(WIDE_W);

	logic [WIDE_W-1:0]   x_q;
	logic [WIDE_W-1:0]   q_q;
	logic [OP_W-1:0]     r_q;
	logic [OP_W-1:0]     den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                run_q;
	logic                done_q;
	logic [OP_W:0]       r_sh;
	logic [OP_W:0]       r_sub;
	logic                q_bit;

	always_comb begin
		r_sh  = {r_q, x_q[WIDE_W-1]};
		r_sub = r_sh - {1'b0, den_q};
		q_bit = (r_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= num;
			q_q   <= '0;
			r_q   <= '0;
			den_q <= den;
		end else if (run_q) begin
			x_q <= x_q << 1;
			q_q <= {q_q[WIDE_W-2:0], q_bit};
			r_q <= q_bit ? r_sub[OP_W-1:0] : r_sh[OP_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

>>> sv/empirical_variogram_binner_unit.sv
// ----------------------------------------------------------------------------
// empirical_variogram_binner_unit
// Bins point pairs by squared distance and keeps per-bin variogram,
// covariance or madogram sums; reads return count, mean and spread.
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and the result
// appears on result for exactly one cycle with done high; the receiver must
// take it then, since the block cannot hold it. Every request walks a chain
// of BINS+1 cells (edge slots and bin accumulators), one cell per cycle.
// Accumulate: prep steps, then a search walk and, when the edges are in order
// and the pair falls in a bin, a second walk that applies it. Write edge and
// clear: one walk. Read: one walk, then five products on a bit-serial 64-bit
// multiplier and one or two quotients on a bit-serial 128-bit divider; a read
// of an empty bin or out of range index ends after the walk. The user must
// write configuration only while busy is low; the block itself does not enforce it.
module empirical_variogram_binner_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [evb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [evb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              start,
	input  evb_pkg::req_t                     request,
	output logic                              busy,
	output logic                              done,
	output evb_pkg::res_t                     result
);
	import evb_pkg::*;

	localparam logic [2:0] PREP_TERM = 3'd3;
	localparam logic [2:0] PREP_SQ   = 3'd4;
	localparam logic [2:0] PREP_LAST = 3'd5;
	localparam logic [2:0] MOP_LAST  = 3'd4;
	localparam int MUL_W = 26;
	localparam logic [WIDE_W-1:0] SAT_POS = WIDE_W'(48'h7FFF_FFFF_FFFF);
	localparam logic [WIDE_W-1:0] SAT_NEG = WIDE_W'(48'h8000_0000_0000);

	state_t state_q, state_d;

	logic [1:0]            method_q;
	logic [1:0]            dims_q;
	logic [IDX_W-1:0]      bins_q;
	logic [IDX_W-1:0]      nb_q;
	logic [1:0]            ndims_q;
	req_t                  req_q;
	res_t                  res_q;
	logic [2:0]            pstep_q;
	logic signed [EDGE_W-1:0] dist_q;
	logic signed [TERM_W-1:0] term_q;
	logic [TSQ_W-1:0]      term_sq_q;
	logic [CNT_W-1:0]      n_q;
	logic signed [SUM_W-1:0] s_q;
	logic [SQ_W-1:0]       q_q;
	logic signed [HT_W-1:0] hs_q;
	logic signed [HT_W-1:0] ts_q;
	logic [2:0]            mop_q;
	logic                  dsel_q;
	logic signed [WIDE_W-1:0] mean_num_q;
	logic signed [WIDE_W-1:0] spread_num_q;
	logic [OP_W-1:0]       pden_q;

	tok_t chain [BINS+2];
	tok_t tok_out;

	logic launch, mul_go, div_go, relaunch_ok, read_ok;

	// prep arithmetic
	logic signed [COORD_W:0]     ax_d;
	logic signed [VALUE_BITS:0]  vd;
	logic signed [TERM_W-1:0]    vd_abs;
	logic signed [MUL_W-1:0]     pm_a, pm_b;
	logic signed [2*MUL_W-1:0]   pm_p;

	// read arithmetic
	logic [SUM_W-1:0]   smag;
	logic [HT_W-1:0]    hmag, tmag;
	logic [OP_W-1:0]    mul_a, mul_b;
	logic               mul_done;
	logic [WIDE_W-1:0]  mul_p;
	logic signed [WIDE_W-1:0] div_numv;
	logic               div_neg;
	logic [WIDE_W-1:0]  div_mag;
	logic [OP_W-1:0]    div_den;
	logic               div_done;
	logic [WIDE_W-1:0]  div_quo;
	logic [OP_W-1:0]    div_rem;
	logic [WIDE_W-1:0]  q_rnd, q_lim, q_sat, q_out;
	logic               vario;

	assign tok_out = chain[BINS+1];
	assign vario = (method_q != MTH_COV) && (method_q != MTH_MADO);

	// ---------------- configuration and state register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= MTH_VARIO;
			dims_q   <= 2'd2;
			bins_q   <= IDX_W'(BINS);
			state_q  <= S_IDLE;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_METHOD: method_q <= cfg_data[1:0];
					REG_DIMS:   dims_q   <= cfg_data[1:0];
					REG_BINS:   bins_q   <= cfg_data[IDX_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_PREP;
			S_PREP:  if (pstep_q == PREP_LAST) state_d = S_PASS;
			S_PASS: begin
				if (tok_out.valid) begin
					if (relaunch_ok) begin
						state_d = S_PASS;
					end else if (read_ok) begin
						state_d = S_LOAD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_LOAD:  state_d = S_MUL;
			S_MUL:   if (mul_done) state_d = (mop_q == MOP_LAST) ? S_DLOAD : S_LOAD;
			S_DLOAD: state_d = S_DIV;
			S_DIV: begin
				if (div_done) state_d = (dsel_q || n_q < CNT_W'(2)) ? S_DONE : S_DLOAD;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- control outputs ----------------
	always_comb begin
		relaunch_ok = req_q.command == CMD_ACC && !tok_out.apply && !tok_out.bad
			&& tok_out.found;
		read_ok = req_q.command == CMD_READ && req_q.bin_index < nb_q
			&& tok_out.n != '0;
		launch = 1'b0;
		mul_go = 1'b0;
		div_go = 1'b0;
		unique case (state_q)
			S_PREP:  launch = (pstep_q == PREP_LAST);
			S_PASS:  launch = tok_out.valid && relaunch_ok;
			S_LOAD:  mul_go = 1'b1;
			S_DLOAD: div_go = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign result = res_q;

	// ---------------- cell chain ----------------
	always_comb begin
		chain[0]          = '0;
		chain[0].valid    = launch;
		chain[0].apply    = (state_q == S_PASS);
		chain[0].cmd      = req_q.command;
		chain[0].method   = method_q;
		chain[0].nb       = nb_q;
		chain[0].idx      = req_q.bin_index;
		chain[0].sq_dist  = dist_q;
		chain[0].term     = term_q;
		chain[0].term_sq  = term_sq_q;
		chain[0].hv       = req_q.head_value;
		chain[0].tv       = req_q.tail_value;
		chain[0].edge_val = req_q.edge_value;
		chain[0].bin      = (state_q == S_PASS) ? tok_out.bin : '0;
	end

	genvar g;
	generate
		for (g = 0; g <= BINS; g++) begin : g_cell
			evb_cell #(.IDX(g)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tok_i  (chain[g]),
				.tok_o  (chain[g+1])
			);
		end
	endgenerate

	// ---------------- prep multiplier ----------------
	always_comb begin
		case (pstep_q)
			3'd0:    ax_d = (COORD_W+1)'(req_q.head_x) - (COORD_W+1)'(req_q.tail_x);
			3'd1:    ax_d = (COORD_W+1)'(req_q.head_y) - (COORD_W+1)'(req_q.tail_y);
			default: ax_d = (COORD_W+1)'(req_q.head_z) - (COORD_W+1)'(req_q.tail_z);
		endcase
		vd = (VALUE_BITS+1)'(req_q.head_value) - (VALUE_BITS+1)'(req_q.tail_value);
		vd_abs = vd[VALUE_BITS] ? -TERM_W'(vd) : TERM_W'(vd);
		if (pstep_q < PREP_TERM) begin
			pm_a = MUL_W'(ax_d);
			pm_b = MUL_W'(ax_d);
		end else if (pstep_q == PREP_TERM) begin
			pm_a = (method_q == MTH_COV) ? MUL_W'(req_q.head_value) : MUL_W'(vd);
			pm_b = (method_q == MTH_COV) ? MUL_W'(req_q.tail_value) : MUL_W'(vd);
		end else begin
			pm_a = MUL_W'(term_q);
			pm_b = MUL_W'(term_q);
		end
		pm_p = (2*MUL_W)'(pm_a) * (2*MUL_W)'(pm_b);
	end

	// ---------------- read arithmetic ----------------
	always_comb begin
		smag = s_q[SUM_W-1] ? SUM_W'(-s_q) : SUM_W'(s_q);
		hmag = hs_q[HT_W-1] ? HT_W'(-hs_q) : HT_W'(hs_q);
		tmag = ts_q[HT_W-1] ? HT_W'(-ts_q) : HT_W'(ts_q);
		case (mop_q)
			3'd0: begin
				mul_a = OP_W'(n_q);
				mul_b = q_q;
			end
			3'd1: begin
				mul_a = OP_W'(smag);
				mul_b = OP_W'(smag);
			end
			3'd2: begin
				mul_a = OP_W'(n_q);
				mul_b = OP_W'(smag);
			end
			3'd3: begin
				mul_a = OP_W'(hmag);
				mul_b = OP_W'(tmag);
			end
			default: begin
				mul_a = OP_W'(n_q);
				mul_b = OP_W'(n_q - 1'b1);
			end
		endcase
	end

	evb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	always_comb begin
		div_numv = dsel_q ? spread_num_q : mean_num_q;
		div_neg  = div_numv[WIDE_W-1];
		div_mag  = div_neg ? WIDE_W'(-div_numv) : WIDE_W'(div_numv);
		if (dsel_q) begin
			div_den = vario ? (pden_q << 2) : pden_q;
		end else if (method_q == MTH_COV) begin
			div_den = pden_q + OP_W'(n_q);
		end else if (method_q == MTH_MADO) begin
			div_den = OP_W'(n_q);
		end else begin
			div_den = OP_W'(n_q) << 1;
		end
		// round half away from zero, then clamp to the 48-bit range
		q_rnd = div_quo + WIDE_W'(div_rem >= div_den - div_rem);
		q_lim = div_neg ? SAT_NEG : SAT_POS;
		q_sat = (q_rnd > q_lim) ? q_lim : q_rnd;
		q_out = div_neg ? -q_sat : q_sat;
	end

	evb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (div_mag << 8),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q   <= request;
					res_q   <= '0;
					dist_q  <= '0;
					pstep_q <= '0;
					dsel_q  <= 1'b0;
					mop_q   <= '0;
					if (bins_q == '0) begin
						nb_q <= IDX_W'(1);
					end else if (bins_q > IDX_W'(BINS)) begin
						nb_q <= IDX_W'(BINS);
					end else begin
						nb_q <= bins_q;
					end
					if (dims_q == '0) begin
						ndims_q <= 2'd1;
					end else if (dims_q > 2'(AXES)) begin
						ndims_q <= 2'(AXES);
					end else begin
						ndims_q <= dims_q;
					end
				end
			end
			S_PREP: begin
				pstep_q <= pstep_q + 1'b1;
				if (pstep_q < PREP_TERM) begin
					if (pstep_q < {1'b0, ndims_q}) begin
						dist_q <= dist_q + EDGE_W'(pm_p);
					end
				end else if (pstep_q == PREP_TERM) begin
					term_q <= (method_q == MTH_MADO) ? vd_abs : TERM_W'(pm_p);
				end else if (pstep_q == PREP_SQ) begin
					term_sq_q <= TSQ_W'(pm_p);
				end
			end
			S_PASS: begin
				if (tok_out.valid) begin
					case (req_q.command)
						CMD_ACC: begin
							if (tok_out.apply) begin
								res_q.status  <= STAT_OK;
								res_q.bin_hit <= tok_out.bin;
							end else if (tok_out.bad) begin
								res_q.status <= STAT_ORDER;
							end else if (!tok_out.found) begin
								res_q.status <= STAT_RANGE;
							end
						end
						CMD_READ: begin
							if (req_q.bin_index >= nb_q) begin
								res_q.status <= STAT_RANGE;
							end else begin
								res_q.bin_hit    <= req_q.bin_index[BIN_W-1:0];
								res_q.pair_count <= tok_out.n;
								n_q        <= tok_out.n;
								s_q        <= tok_out.s;
								q_q        <= tok_out.q;
								hs_q       <= tok_out.hs;
								ts_q       <= tok_out.ts;
								mean_num_q <= WIDE_W'(tok_out.s);
							end
						end
						CMD_WRITE: begin
							if (req_q.bin_index > IDX_W'(BINS)) res_q.status <= STAT_RANGE;
						end
						default: ;
					endcase
				end
			end
			S_MUL: begin
				if (mul_done) begin
					mop_q <= mop_q + 1'b1;
					case (mop_q)
						3'd0: spread_num_q <= mul_p;
						3'd1: spread_num_q <= spread_num_q - mul_p;
						3'd2: begin
							if (method_q == MTH_COV) begin
								mean_num_q <= s_q[SUM_W-1] ? -mul_p : mul_p;
							end
						end
						3'd3: begin
							if (method_q == MTH_COV) begin
								mean_num_q <= (hs_q[HT_W-1] != ts_q[HT_W-1])
									? mean_num_q + mul_p : mean_num_q - mul_p;
							end
						end
						default: pden_q <= mul_p[OP_W-1:0];
					endcase
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (!dsel_q) begin
						res_q.mean_value <= q_out[OUT_W-1:0];
					end else begin
						res_q.spread_value <= q_out[OUT_W-1:0];
						res_q.spread_valid <= 1'b1;
					end
					dsel_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> bench/tb_empirical_variogram_binner_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_empirical_variogram_binner_unit
// Self-checking bench for the variogram binner. Requests are predicted by a
// scoreboard that mirrors the edge table, bin sums and registers, and every
// strobed result is compared with the oldest prediction. Phases step through
// register settings and sender idle patterns, with directed corner requests
// first and then random pair, read, edge and clear requests.
// ----------------------------------------------------------------------------
module tb_empirical_variogram_binner_unit;
	import evb_pkg::*;

	localparam int  LIMIT    = 3000000;
	localparam longint SUMHI = 64'sh7FFFFFFFFFFF;
	localparam longint HTHI  = 64'sh7FFFFFFFFF;
	localparam longint unsigned SQHI = 64'h7FFFFFFFFFFFFFFF;
	localparam int unsigned CNTHI = 24'hFFFFFF;

	class pair_bin_board;
		longint          edge_tab[BINS+1];
		longint          bsum[BINS];
		longint unsigned bsq[BINS];
		int unsigned     bcnt[BINS];
		longint          bhead[BINS];
		longint          btail[BINS];
		logic [1:0]      mth;
		logic [1:0]      dims;
		logic [5:0]      nbins;
		res_t            expected_results[$];
		int              errors;

		function new();
			foreach (edge_tab[i]) edge_tab[i] = 0;
			clear_sums();
			mth = MTH_VARIO;
			dims = 2;
			nbins = 32;
			errors = 0;
		endfunction

		function void clear_sums();
			foreach (bsum[i]) begin
				bsum[i] = 0; bsq[i] = 0; bcnt[i] = 0; bhead[i] = 0; btail[i] = 0;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_METHOD: mth = data[1:0];
				REG_DIMS:   dims = data[1:0];
				REG_BINS:   nbins = data;
				default: ;
			endcase
		endfunction

		function int active_bins();
			if (nbins == 0) return 1;
			if (nbins > BINS) return BINS;
			return nbins;
		endfunction

		function longint sat(longint a, longint b, longint hi);
			longint s;
			s = a + b;
			if (s > hi) return hi;
			if (s < -hi - 1) return -hi - 1;
			return s;
		endfunction

		// round num*256/den to nearest, ties away from zero, clamp to 48 bits
		function logic [OUT_W-1:0] to_fixed(logic signed [127:0] num, logic [127:0] den);
			logic [127:0] mag, quo, rem, lim, v;
			bit neg;
			if (den == 0) return '0;
			neg = num < 0;
			mag = neg ? -num : num;
			mag = mag << 8;
			quo = mag / den;
			rem = mag % den;
			if (rem >= den - rem) quo = quo + 1;
			lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
			if (quo > lim) quo = lim;
			v = neg ? -quo : quo;
			return v[OUT_W-1:0];
		endfunction

		function res_t accumulate(req_t r);
			res_t res;
			int nb, nd, lo, up, mid, b;
			longint d, dsq, h, t, x2;
			longint unsigned sqv;
			res = '0;
			nb = active_bins();
			nd = (dims == 0) ? 1 : dims;
			dsq = 0;
			for (int a = 0; a < nd; a++) begin
				case (a)
					0: d = longint'(r.head_x) - longint'(r.tail_x);
					1: d = longint'(r.head_y) - longint'(r.tail_y);
					default: d = longint'(r.head_z) - longint'(r.tail_z);
				endcase
				dsq += d * d;
			end
			for (int a = 0; a < nb; a++)
				if (edge_tab[a] >= edge_tab[a+1]) begin
					res.status = STAT_ORDER;
					return res;
				end
			if (!(dsq > edge_tab[0] && dsq <= edge_tab[nb])) begin
				res.status = STAT_RANGE;
				return res;
			end
			lo = 0;
			up = nb - 1;
			while (lo < up) begin
				mid = (lo + up + 1) / 2;
				if (dsq > edge_tab[mid]) lo = mid;
				else up = mid - 1;
			end
			b = lo;
			res.bin_hit = BIN_W'(b);
			if (bcnt[b] >= CNTHI) return res;
			h = longint'(r.head_value);
			t = longint'(r.tail_value);
			if (mth == MTH_COV) begin
				x2 = h * t;
				bhead[b] = sat(bhead[b], h, HTHI);
				btail[b] = sat(btail[b], t, HTHI);
			end else if (mth == MTH_MADO) begin
				x2 = (h > t) ? h - t : t - h;
			end else begin
				x2 = (h - t) * (h - t);
			end
			bsum[b] = sat(bsum[b], x2, SUMHI);
			sqv = (x2 < 0) ? longint'(-x2) : x2;
			sqv = sqv * sqv;
			bsq[b] = (sqv > SQHI - bsq[b]) ? SQHI : bsq[b] + sqv;
			bcnt[b]++;
			return res;
		endfunction

		function res_t read_bin(req_t r);
			res_t res;
			int idx;
			logic signed [127:0] n, s, smag, q, hs, ts, spread_num;
			res = '0;
			idx = int'(r.bin_index);
			if (idx >= active_bins()) begin
				res.status = STAT_RANGE;
				return res;
			end
			res.bin_hit = BIN_W'(idx);
			res.pair_count = CNT_W'(bcnt[idx]);
			if (bcnt[idx] == 0) return res;
			n = $signed({96'd0, bcnt[idx]});
			s = bsum[idx];
			smag = (s < 0) ? -s : s;
			q = $signed({64'd0, bsq[idx]});
			spread_num = n * q - smag * smag;
			if (mth == MTH_COV) begin
				hs = bhead[idx];
				ts = btail[idx];
				res.mean_value = to_fixed(n * s - hs * ts, n * n);
			end else if (mth == MTH_MADO) begin
				res.mean_value = to_fixed(s, n);
			end else begin
				res.mean_value = to_fixed(s, 2 * n);
			end
			if (bcnt[idx] >= 2) begin
				res.spread_value = to_fixed(spread_num,
					(mth == MTH_COV || mth == MTH_MADO) ? n * (n - 1) : 4 * n * (n - 1));
				res.spread_valid = 1'b1;
			end
			return res;
		endfunction

		function void note_request(req_t r);
			res_t res;
			res = '0;
			case (r.command)
				CMD_ACC:  res = accumulate(r);
				CMD_READ: res = read_bin(r);
				CMD_WRITE: begin
					if (r.bin_index <= BINS) edge_tab[r.bin_index] = longint'(r.edge_value);
					else res.status = STAT_RANGE;
				end
				default: clear_sums();
			endcase
			expected_results.push_back(res);
		endfunction

		function void check_result(res_t got);
			res_t exp_r;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing pending: %p", $time, got);
				errors++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.status !== exp_r.status) begin
				$display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
				errors++;
			end
			if (got.bin_hit !== exp_r.bin_hit) begin
				$display("%0t: bin_hit exp %0d got %0d", $time, exp_r.bin_hit, got.bin_hit);
				errors++;
			end
			if (got.pair_count !== exp_r.pair_count) begin
				$display("%0t: pair_count exp %0d got %0d", $time,
					exp_r.pair_count, got.pair_count);
				errors++;
			end
			if (got.mean_value !== exp_r.mean_value) begin
				$display("%0t: mean_value exp %0d got %0d", $time,
					exp_r.mean_value, got.mean_value);
				errors++;
			end
			if (got.spread_value !== exp_r.spread_value) begin
				$display("%0t: spread_value exp %0d got %0d", $time,
					exp_r.spread_value, got.spread_value);
				errors++;
			end
			if (got.spread_valid !== exp_r.spread_valid) begin
				$display("%0t: spread_valid exp %0d got %0d", $time,
					exp_r.spread_valid, got.spread_valid);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	req_t                  request = '0;
	logic                  busy;
	logic                  done;
	res_t                  result;

	pair_bin_board board = new();
	int     cycles = 0;
	int     gap_pct = 0;
	longint edge_base, edge_step;
	int     reach;

	empirical_variogram_binner_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .start(start), .request(request), .busy(busy),
		.done(done), .result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_empirical_variogram_binner_unit NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done) board.check_result(result);

	function automatic req_t noise_req(logic [1:0] cmd);
		req_t r;
		r.command = cmd;
		r.head_x = COORD_W'($urandom); r.head_y = COORD_W'($urandom);
		r.head_z = COORD_W'($urandom);
		r.tail_x = COORD_W'($urandom); r.tail_y = COORD_W'($urandom);
		r.tail_z = COORD_W'($urandom);
		r.head_value = VALUE_BITS'($urandom); r.tail_value = VALUE_BITS'($urandom);
		r.bin_index = IDX_W'($urandom);
		r.edge_value = EDGE_W'({$urandom, $urandom});
		return r;
	endfunction

	// pair whose per-axis separation stays within the current edge reach
	function automatic req_t near_pair();
		req_t r;
		r = noise_req(CMD_ACC);
		r.head_x = COORD_W'($urandom_range(60000) - 30000);
		r.head_y = COORD_W'($urandom_range(60000) - 30000);
		r.head_z = COORD_W'($urandom_range(60000) - 30000);
		r.tail_x = COORD_W'(r.head_x + $urandom_range(2 * reach) - reach);
		r.tail_y = COORD_W'(r.head_y + $urandom_range(2 * reach) - reach);
		r.tail_z = COORD_W'(r.head_z + $urandom_range(2 * reach) - reach);
		return r;
	endfunction

	task automatic issue_request(req_t r);
		if ($urandom_range(99) < gap_pct) begin
			// drop start and leave a random idle gap once the block is free
			@(negedge clk);
			start = 1'b0;
			while (busy) @(negedge clk);
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		request = r;
		do @(posedge clk); while (busy);
		board.note_request(r);
	endtask

	task automatic edge_write(int slot, longint val);
		req_t r;
		r = noise_req(CMD_WRITE);
		r.bin_index = IDX_W'(slot);
		r.edge_value = EDGE_W'(val);
		issue_request(r);
	endtask

	task automatic read_request(int idx);
		req_t r;
		r = noise_req(CMD_READ);
		r.bin_index = IDX_W'(idx);
		issue_request(r);
	endtask

	// hold until every request has answered, then let the block settle
	task automatic wait_quiet();
		@(negedge clk);
		start = 1'b0;
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		board.set_register(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic load_edges();
		int nd;
		longint top;
		edge_base = ($urandom_range(3) == 0) ? 0 : -1;
		edge_step = $urandom_range(1, 400);
		for (int k = 0; k <= BINS; k++) edge_write(k, edge_base + k * edge_step);
		nd = (board.dims == 0) ? 1 : board.dims;
		top = edge_base + board.active_bins() * edge_step;
		reach = 1;
		while (nd * reach * reach < top + top / 4 && reach < 20000) reach++;
	endtask

	task automatic random_phase(int count);
		int pick, nb;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			nb = board.active_bins();
			if (pick < 60) begin
				issue_request(near_pair());
			end else if (pick < 68) begin
				issue_request(noise_req(CMD_ACC));
			end else if (pick < 88) begin
				read_request(($urandom_range(9) == 0) ? $urandom_range(63)
					: $urandom_range(nb - 1));
			end else if (pick < 93) begin
				// rewrite an edge unchanged, or aim at a slot that does not exist
				if ($urandom_range(1)) begin
					pick = $urandom_range(BINS);
					edge_write(pick, edge_base + pick * edge_step);
				end else begin
					edge_write($urandom_range(BINS + 1, 63), {$urandom, $urandom});
				end
			end else if (pick < 96) begin
				issue_request(noise_req(CMD_CLEAR));
			end else begin
				// break ordering once, then restore it
				pick = $urandom_range(1, BINS);
				edge_write(pick, edge_base + (pick - 1) * edge_step);
				issue_request(near_pair());
				edge_write(pick, edge_base + pick * edge_step);
			end
		end
		for (int b = 0; b < board.active_bins(); b += 3) read_request(b);
	endtask

	task automatic directed_part();
		req_t r;
		edge_write(0, -36'sd34359738368);
		edge_write(BINS, 36'sd34359738367);
		read_request(0);
		r = noise_req(CMD_ACC);
		r.tail_x = r.head_x; r.tail_y = r.head_y;
		r.head_value = -12'sd2048; r.tail_value = 12'sd2047;
		issue_request(r);
		read_request(0);
		r.head_value = 12'sd2047; r.tail_value = -12'sd2048;
		issue_request(r);
		read_request(0);
		r.head_x = -16'sd32768; r.tail_x = 16'sd32767;
		r.head_y = 16'sd32767; r.tail_y = -16'sd32768;
		issue_request(r);
		read_request(BINS - 1);
		read_request(BINS);
		read_request(63);
		edge_write(BINS + 1, 36'sd5);
		edge_write(63, -36'sd1);
		edge_write(5, edge_base + 4 * edge_step);
		issue_request(near_pair());
		edge_write(5, edge_base + 5 * edge_step);
		edge_write(0, edge_base);
		edge_write(BINS, edge_base + BINS * edge_step);
		issue_request(near_pair());
		issue_request(noise_req(CMD_CLEAR));
		read_request(0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_edges();
		directed_part();
		random_phase(35);

		for (int ph = 0; ph < 8; ph++) begin
			wait_quiet();
			case (ph)
				0: begin write_register(REG_METHOD, MTH_COV);  write_register(REG_DIMS, 3);
					write_register(REG_BINS, 32); end
				1: begin write_register(REG_METHOD, MTH_MADO); write_register(REG_DIMS, 1);
					write_register(REG_BINS, 1); end
				2: begin write_register(REG_METHOD, MTH_VARIO); write_register(REG_DIMS, 2);
					write_register(REG_BINS, 7); end
				3: begin write_register(REG_METHOD, 2'd3);     write_register(REG_DIMS, 0);
					write_register(REG_BINS, 0); end
				4: begin write_register(REG_METHOD, MTH_COV);  write_register(REG_DIMS, 1);
					write_register(REG_BINS, 40); end
				5: begin write_register(REG_METHOD, MTH_MADO); write_register(REG_DIMS, 3);
					write_register(REG_BINS, 63); end
				6: write_register(REG_METHOD, MTH_VARIO);
				default: begin write_register(REG_METHOD, MTH_COV);
					write_register(REG_BINS, 16); end
			endcase
			case (ph % 4)
				1: gap_pct = 61;
				3: gap_pct = 34;
				default: gap_pct = 0;
			endcase
			// the method is not latched: sums from the last phase read under the new one
			if (ph != 6) load_edges();
			random_phase(35);
		end

		wait_quiet();
		if (board.errors == 0)
			$display("tb_empirical_variogram_binner_unit OK");
		else
			$display("tb_empirical_variogram_binner_unit NOT OK");
		$finish;
	end

endmodule
